>>> rtl/core/top_k_magnitude_select_defines.svh
// Assertion macros for the top-k magnitude select RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TOP_K_MAGNITUDE_SELECT_DEFINES_SVH
`define TOP_K_MAGNITUDE_SELECT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TKMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TKMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tkms_pkg.sv
// Shared types, constants and helpers for the top-k magnitude select block.
// No dependencies; used by tkms_ctrl, tkms_datapath and the top level.
package tkms_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int INDEX_BITS_DEF = 10;

    localparam int VAL_W    = 32;
    localparam int MAG_W    = 31;
    localparam int TAG_W    = 10;
    localparam int MARGIN_W = 20;
    localparam int THRESH_W = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(11);
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = '0;

    localparam logic [CFG_IDX_W-1:0] REG_INSERT_MARGIN    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_THRESHOLD = CFG_IDX_W'(1);

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic signed [VAL_W-1:0] amplitude;
        logic [TAG_W-1:0]        occ_first;
        logic [TAG_W-1:0]        occ_second;
        logic [TAG_W-1:0]        vir_first;
        logic [TAG_W-1:0]        vir_second;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_amplitude;
        logic [TAG_W-1:0]        out_occ_first;
        logic [TAG_W-1:0]        out_occ_second;
        logic [TAG_W-1:0]        out_vir_first;
        logic [TAG_W-1:0]        out_vir_second;
        logic                    list_empty;
        logic                    last_result;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_INS,
        S_DRQ,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic load_in;
        logic cmp;
        logic ins;
        logic qual;
        logic shift;
        logic emit;
        logic emit_empty;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic q_any;
        logic q_head;
        logic q_rest_any;
        logic out_free;
    } t_sts;

    // Saturating magnitude: -2^31 maps to 2^31-1.
    function automatic logic [MAG_W-1:0] mag(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] neg;
        neg = ~v + VAL_W'(1);
        if (!v[VAL_W-1]) begin
            return v[MAG_W-1:0];
        end else if (neg[VAL_W-1]) begin
            return {MAG_W{1'b1}};
        end else begin
            return neg[MAG_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/top_k_magnitude_select.sv
// Top level of the top-k magnitude select block.
// Depends on tkms_pkg, tkms_ctrl and tkms_datapath.
//
// Keeps the LIST_DEPTH largest-magnitude Q1.30 amplitudes with their four
// orbital tags, in descending order. Input beats (i_in_valid/o_in_stall)
// carry either a push or a drain request; result beats leave on
// o_out_valid/i_out_stall from an output register, so a waiting result
// does not block the next input beat.
// A push runs through capture, a parallel compare of the new magnitude
// against each entry's magnitude plus the insert margin, then the
// shift-insert with a prefix OR over the list, before the next input beat
// is accepted. A drain qualifies every entry against report_threshold,
// then shifts the list toward the head, skipping entries below threshold
// and emitting each passing one up to the last. An empty drain sends one
// beat with list_empty and last_result set. While the receiver stalls,
// the result beat holds and the drain waits before its next emit.
// Reset (synchronous, active low) clears the list to zeros, sets
// insert_margin to 0 and report_threshold to 11. Config writes land at
// once when i_cfg_we is high; indexes beyond the register list are ignored.
module top_k_magnitude_select #(
    parameter int LIST_DEPTH = tkms_pkg::LIST_DEPTH_DEF,
    parameter int INDEX_BITS = tkms_pkg::INDEX_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tkms_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tkms_pkg::t_out                  o_out,
    input  logic                            i_cfg_we,
    input  logic [tkms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tkms_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tkms_pkg::t_cmd cmd;
    tkms_pkg::t_sts sts;

    tkms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in.req_type),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tkms_datapath #(
        .LIST_DEPTH (LIST_DEPTH),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> rtl/core/tkms_ctrl.sv
// Sequencer for the top-k magnitude select block: push and drain flow.
// Depends on tkms_pkg; drives tkms_datapath through t_cmd, reads t_sts.
module tkms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    output logic           o_in_stall,
    input  tkms_pkg::t_sts i_sts,
    output tkms_pkg::t_cmd o_cmd
);

    tkms_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkms_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            tkms_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_req_type == tkms_pkg::REQ_DRAIN) ?
                              tkms_pkg::S_DRQ : tkms_pkg::S_CMP;
                end
            end
            tkms_pkg::S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = tkms_pkg::S_INS;
            end
            tkms_pkg::S_INS: begin
                o_cmd.ins = 1'b1;
                n_state   = tkms_pkg::S_IDLE;
            end
            tkms_pkg::S_DRQ: begin
                o_cmd.qual = 1'b1;
                n_state    = tkms_pkg::S_DRAIN;
            end
            tkms_pkg::S_DRAIN: begin
                if (!i_sts.q_any) begin
                    // nothing passes: one empty beat, and clear the list
                    if (i_sts.out_free) begin
                        o_cmd.emit_empty = 1'b1;
                        o_cmd.clear      = 1'b1;
                        n_state          = tkms_pkg::S_IDLE;
                    end
                end else if (i_sts.q_head) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        if (i_sts.q_rest_any) begin
                            o_cmd.shift = 1'b1;
                        end else begin
                            o_cmd.clear = 1'b1;
                            n_state     = tkms_pkg::S_IDLE;
                        end
                    end
                end else begin
                    // skip an entry below threshold
                    o_cmd.shift = 1'b1;
                end
            end
            default: begin
                n_state = tkms_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/tkms_datapath.sv
// Datapath for the top-k magnitude select block: kept list, compares,
// insertion shift, drain shift-out, config registers and output register.
// Depends on tkms_pkg and top_k_magnitude_select_defines.svh.
`include "top_k_magnitude_select_defines.svh"

module tkms_datapath #(
    parameter int LIST_DEPTH = tkms_pkg::LIST_DEPTH_DEF,
    parameter int INDEX_BITS = tkms_pkg::INDEX_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tkms_pkg::t_cmd                    i_cmd,
    output tkms_pkg::t_sts                    o_sts,
    input  tkms_pkg::t_in                     i_in,
    input  logic                              i_cfg_we,
    input  logic [tkms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tkms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tkms_pkg::t_out                    o_out
);

    // stored tag width: tag bits above INDEX_BITS are dropped
    localparam int TB = (INDEX_BITS < tkms_pkg::TAG_W) ? INDEX_BITS : tkms_pkg::TAG_W;
    localparam int LEVELS = $clog2(LIST_DEPTH);
    localparam int VW = tkms_pkg::VAL_W;
    localparam int MW = tkms_pkg::MAG_W;

    // kept list
    logic [VW-1:0]        r_val [LIST_DEPTH];
    logic [3:0][TB-1:0]   r_tag [LIST_DEPTH];

    logic [tkms_pkg::MARGIN_W-1:0] r_margin;
    logic [tkms_pkg::THRESH_W-1:0] r_thresh;

    logic [VW-1:0]       r_new_val;
    logic [3:0][TB-1:0]  r_new_tag;
    logic [MW-1:0]       r_new_mag;

    logic [LIST_DEPTH-1:0] r_gt;
    logic [LIST_DEPTH-1:0] r_q;

    logic           r_out_valid;
    tkms_pkg::t_out r_out;

    logic [MW-1:0]         cell_mag [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] gt_vec;
    logic [LIST_DEPTH-1:0] q_vec;
    logic [LEVELS:0][LIST_DEPTH-1:0] pre;
    logic [LIST_DEPTH-1:0] gt_before;
    logic [LIST_DEPTH-1:0] ins_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= tkms_pkg::MARGIN_RESET;
            r_thresh <= tkms_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tkms_pkg::REG_INSERT_MARGIN:
                    r_margin <= i_cfg_data[tkms_pkg::MARGIN_W-1:0];
                tkms_pkg::REG_REPORT_THRESHOLD:
                    r_thresh <= i_cfg_data[tkms_pkg::THRESH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_new_val    <= i_in.amplitude;
            r_new_mag    <= tkms_pkg::mag(i_in.amplitude);
            r_new_tag[0] <= i_in.occ_first[TB-1:0];
            r_new_tag[1] <= i_in.occ_second[TB-1:0];
            r_new_tag[2] <= i_in.vir_first[TB-1:0];
            r_new_tag[3] <= i_in.vir_second[TB-1:0];
        end
    end

    // per-entry compares, all in parallel
    always_comb begin
        for (int k = 0; k < LIST_DEPTH; k++) begin
            cell_mag[k] = tkms_pkg::mag(r_val[k]);
            gt_vec[k]   = {1'b0, r_new_mag} >
                          ({1'b0, cell_mag[k]} + VW'(r_margin));
            q_vec[k]    = cell_mag[k] > r_thresh;
        end
    end

    // first-hit position by a log-depth prefix OR
    always_comb begin
        pre[0] = r_gt;
        for (int s = 0; s < LEVELS; s++) begin
            for (int k = 0; k < LIST_DEPTH; k++) begin
                if (k >= (1 << s)) begin
                    pre[s+1][k] = pre[s][k] | pre[s][k - (1 << s)];
                end else begin
                    pre[s+1][k] = pre[s][k];
                end
            end
        end
        gt_before = pre[LEVELS] << 1;
        ins_pos   = r_gt & ~gt_before;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_gt <= gt_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_cmd.clear) begin
            r_q <= '0;
        end else if (i_cmd.qual) begin
            r_q <= q_vec;
        end else if (i_cmd.shift) begin
            r_q <= r_q >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < LIST_DEPTH; k++) begin
                r_val[k] <= '0;
                r_tag[k] <= '0;
            end
        end else if (i_cmd.ins) begin
            for (int k = 0; k < LIST_DEPTH; k++) begin
                if (k > 0 && gt_before[k]) begin
                    r_val[k] <= r_val[k-1];
                    r_tag[k] <= r_tag[k-1];
                end else if (ins_pos[k]) begin
                    r_val[k] <= r_new_val;
                    r_tag[k] <= r_new_tag;
                end
            end
        end else if (i_cmd.shift) begin
            // advance the list toward the head
            for (int k = 0; k < LIST_DEPTH; k++) begin
                if (k == LIST_DEPTH - 1) begin
                    r_val[k] <= '0;
                    r_tag[k] <= '0;
                end else begin
                    r_val[k] <= r_val[k+1];
                    r_tag[k] <= r_tag[k+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_empty) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_empty) begin
            r_out.out_amplitude  <= '0;
            r_out.out_occ_first  <= '0;
            r_out.out_occ_second <= '0;
            r_out.out_vir_first  <= '0;
            r_out.out_vir_second <= '0;
            r_out.list_empty     <= 1'b1;
            r_out.last_result    <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out.out_amplitude  <= r_val[0];
            r_out.out_occ_first  <= tkms_pkg::TAG_W'(r_tag[0][0]);
            r_out.out_occ_second <= tkms_pkg::TAG_W'(r_tag[0][1]);
            r_out.out_vir_first  <= tkms_pkg::TAG_W'(r_tag[0][2]);
            r_out.out_vir_second <= tkms_pkg::TAG_W'(r_tag[0][3]);
            r_out.list_empty     <= 1'b0;
            r_out.last_result    <= ~(|(r_q >> 1));
        end
    end

    always_comb begin
        o_sts.q_any      = |r_q;
        o_sts.q_head     = r_q[0];
        o_sts.q_rest_any = |(r_q >> 1);
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TKMS_ASSERT_NOW(a_ins_one_slot, i_clk, i_rst_n, i_cmd.ins, $onehot0(ins_pos),
        "insertion picked more than one slot")
    `TKMS_ASSERT_NOW(a_emit_slot_free, i_clk, i_rst_n, i_cmd.emit || i_cmd.emit_empty,
        !r_out_valid || !i_out_stall, "beat overwritten before it was taken")
    `TKMS_ASSERT_NEXT(a_clear_head, i_clk, i_rst_n, i_cmd.clear,
        r_val[0] == '0 && r_q == '0, "list not cleared after drain")
    `TKMS_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n, r_out_valid && r_out.list_empty,
        r_out.last_result && r_out.out_amplitude == '0, "empty beat malformed")

endmodule

>>> test/top_k_checker.sv
// Checker for top_k_magnitude_select: keeps its own sorted top-k list,
// predicts drain beats and compares every result beat. Depends on tkms_pkg.
`timescale 1ns / 1ps

module top_k_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  tkms_pkg::t_in                   i_in,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  tkms_pkg::t_out                  i_out,
    input  logic                            i_cfg_we,
    input  logic [tkms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tkms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_due
);

    localparam int DEPTH      = tkms_pkg::LIST_DEPTH_DEF;
    localparam int MAX_REPORT = 10;
    localparam int VW         = tkms_pkg::VAL_W;
    localparam int TW         = tkms_pkg::TAG_W;
    localparam int MW         = tkms_pkg::MAG_W;

    typedef struct packed {
        logic signed [VW-1:0] amp;
        logic [TW-1:0]        occ_first;
        logic [TW-1:0]        occ_second;
        logic [TW-1:0]        vir_first;
        logic [TW-1:0]        vir_second;
    } t_entry;

    t_entry                          kept [DEPTH];
    logic [tkms_pkg::MARGIN_W-1:0]   margin;
    logic [tkms_pkg::THRESH_W-1:0]   threshold;
    tkms_pkg::t_out                  drain_beats_due [$];
    int                              errors = 0;

    initial begin
        o_errors = 0;
        o_due    = 0;
    end

    // -2^31 has no positive twin, so its magnitude saturates.
    function automatic logic [MW-1:0] abs_sat(input logic signed [VW-1:0] v);
        if (v == {1'b1, {(VW-1){1'b0}}}) begin
            return '1;
        end
        return (v < 0) ? MW'(-v) : MW'(v);
    endfunction

    task automatic rank_insert(input tkms_pkg::t_in beat);
        int     pos;
        t_entry fresh;
        pos = -1;
        for (int k = 0; k < DEPTH; k++) begin
            if (pos < 0 && {1'b0, abs_sat(beat.amplitude)} >
                    {1'b0, abs_sat(kept[k].amp)} + 32'(margin)) begin
                pos = k;
            end
        end
        if (pos >= 0) begin
            fresh = {beat.amplitude, beat.occ_first, beat.occ_second,
                     beat.vir_first, beat.vir_second};
            for (int k = DEPTH - 1; k > pos; k--) begin
                kept[k] = kept[k-1];
            end
            kept[pos] = fresh;
        end
    endtask

    task automatic drain_list();
        int             last_k;
        tkms_pkg::t_out beat;
        last_k = -1;
        for (int k = 0; k < DEPTH; k++) begin
            if (abs_sat(kept[k].amp) > threshold) begin
                last_k = k;
            end
        end
        if (last_k < 0) begin
            beat             = '0;
            beat.list_empty  = 1'b1;
            beat.last_result = 1'b1;
            drain_beats_due.push_back(beat);
        end
        for (int k = 0; k <= last_k; k++) begin
            if (abs_sat(kept[k].amp) > threshold) begin
                beat                = '0;
                beat.out_amplitude  = kept[k].amp;
                beat.out_occ_first  = kept[k].occ_first;
                beat.out_occ_second = kept[k].occ_second;
                beat.out_vir_first  = kept[k].vir_first;
                beat.out_vir_second = kept[k].vir_second;
                beat.last_result    = (k == last_k);
                drain_beats_due.push_back(beat);
            end
        end
        for (int k = 0; k < DEPTH; k++) begin
            kept[k] = '0;
        end
    endtask

    task automatic check_beat(input tkms_pkg::t_out got);
        tkms_pkg::t_out want;
        if (drain_beats_due.size() == 0) begin
            if (errors < MAX_REPORT) begin
                $display("%0t: result beat with nothing expected: amp %h", $realtime,
                         got.out_amplitude);
            end
            errors++;
            return;
        end
        want = drain_beats_due.pop_front();
        if (got.out_amplitude !== want.out_amplitude ||
                got.out_occ_first !== want.out_occ_first ||
                got.out_occ_second !== want.out_occ_second ||
                got.out_vir_first !== want.out_vir_first ||
                got.out_vir_second !== want.out_vir_second ||
                got.list_empty !== want.list_empty ||
                got.last_result !== want.last_result) begin
            if (errors < MAX_REPORT) begin
                $display("%0t: result mismatch", $realtime);
                $display("  expected amp %h tags %0d %0d %0d %0d empty %b last %b",
                         want.out_amplitude, want.out_occ_first, want.out_occ_second,
                         want.out_vir_first, want.out_vir_second, want.list_empty,
                         want.last_result);
                $display("  actual   amp %h tags %0d %0d %0d %0d empty %b last %b",
                         got.out_amplitude, got.out_occ_first, got.out_occ_second,
                         got.out_vir_first, got.out_vir_second, got.list_empty,
                         got.last_result);
            end
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                kept[k] = '0;
            end
            margin    = tkms_pkg::MARGIN_RESET;
            threshold = tkms_pkg::THRESH_RESET;
            drain_beats_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tkms_pkg::REG_INSERT_MARGIN: begin
                        margin = i_cfg_data[tkms_pkg::MARGIN_W-1:0];
                    end
                    tkms_pkg::REG_REPORT_THRESHOLD: begin
                        threshold = i_cfg_data[tkms_pkg::THRESH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                check_beat(i_out);
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in.req_type == tkms_pkg::REQ_DRAIN) begin
                    drain_list();
                end else begin
                    rank_insert(i_in);
                end
            end
        end
        o_errors <= errors;
        o_due    <= drain_beats_due.size();
    end

endmodule

>>> test/tb.sv
// Stimulus and verdict for top_k_magnitude_select: directed pushes and drains,
// then random rounds of pushes and drains under several register settings.
// Depends on tkms_pkg, top_k_magnitude_select and top_k_checker.
`timescale 1ns / 1ps

module tb;

    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 52;
    localparam int MAX_WAIT      = 19;
    localparam int SETTLE_CYCLES = 24;
    localparam int LIMIT_NS      = 2_000_000;
    localparam int VW            = tkms_pkg::VAL_W;
    localparam int TW            = tkms_pkg::TAG_W;
    localparam int IW            = tkms_pkg::CFG_IDX_W;
    localparam int DW            = tkms_pkg::CFG_DATA_W;

    localparam logic [IW-1:0] REG_UNMAPPED = IW'(3);
    localparam logic [VW-1:0] AMP_MOST_NEG = 32'h8000_0000;
    localparam logic [VW-1:0] AMP_MOST_POS = 32'h7FFF_FFFF;
    localparam logic [VW-1:0] AMP_ONE      = 32'h4000_0000;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    tkms_pkg::t_in  in_beat;
    logic           out_valid;
    logic           out_stall = 1'b0;
    tkms_pkg::t_out out_beat;
    logic           cfg_we;
    logic [IW-1:0]  cfg_idx;
    logic [DW-1:0]  cfg_data;
    int             errors;
    int             due;

    bit send_burst = 1'b0;
    bit take_burst = 1'b0;
    int stall_left = 0;
    int stall_draw;
    int beats_taken = 0;

    always #2 clk = ~clk;

    top_k_magnitude_select uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    top_k_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_due       (due)
    );

    // Draw a fresh stall after every taken beat; flip quiet stretches now and then.
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            beats_taken++;
            if (beats_taken % 24 == 0) begin
                take_burst = ($urandom_range(0, 2) == 0);
            end
            stall_draw = take_burst ? 0 : $urandom_range(0, MAX_WAIT);
            stall_left <= stall_draw;
            out_stall  <= (stall_draw != 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left != 1);
        end
    end

    function automatic logic [4*TW-1:0] rand_tags();
        return (4*TW)'({$urandom(), $urandom()});
    endfunction

    function automatic tkms_pkg::t_in make_push(input logic [VW-1:0] amp,
                                                input logic [4*TW-1:0] tags);
        tkms_pkg::t_in b;
        b.req_type  = tkms_pkg::REQ_PUSH;
        b.amplitude = amp;
        {b.occ_first, b.occ_second, b.vir_first, b.vir_second} = tags;
        return b;
    endfunction

    // Drain payload fields are don't-care; fill them anyway.
    function automatic tkms_pkg::t_in make_drain();
        tkms_pkg::t_in b;
        b          = make_push($urandom(), rand_tags());
        b.req_type = tkms_pkg::REQ_DRAIN;
        return b;
    endfunction

    function automatic logic [VW-1:0] pick_amplitude(
            input logic [tkms_pkg::THRESH_W-1:0] thresh);
        longint        near;
        logic [VW-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       v = AMP_MOST_NEG;
                    1:       v = AMP_MOST_POS;
                    2:       v = AMP_MOST_NEG + 1;
                    3:       v = '0;
                    4:       v = 32'd1;
                    default: v = '1;
                endcase
            end
            1, 2: begin
                // straddle the report threshold
                near = longint'(thresh) + $urandom_range(0, 8) - 4;
                if (near < 0) begin
                    near = 0;
                end
                if (near > longint'(AMP_MOST_POS)) begin
                    near = longint'(AMP_MOST_POS);
                end
                v = near[VW-1:0];
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            3, 4, 5: begin
                // keep values within reach of the insert margin
                v = $urandom_range(0, 2**21 - 1);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic send_beat(input tkms_pkg::t_in beat);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Hold off until every drain beat is back and the list logic has settled.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx,
                             input logic [DW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        #(LIMIT_NS);
        $display("top_k_magnitude_select verification failed");
        $finish;
    end

    initial begin
        int            sent;
        int            round;
        logic [DW-1:0] margin_word;
        logic [DW-1:0] thresh_word;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_beat  <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= '0;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, margin 0 and threshold 11.
        send_beat(make_drain());
        send_beat(make_push(AMP_MOST_NEG, '1));
        send_beat(make_push(AMP_MOST_POS, '0));
        send_beat(make_push(AMP_ONE, rand_tags()));
        send_beat(make_push(-AMP_ONE, rand_tags()));
        send_beat(make_push('0, rand_tags()));
        send_beat(make_push(32'd12, rand_tags()));
        send_beat(make_push(-32'd12, rand_tags()));
        send_beat(make_push(32'd11, rand_tags()));
        send_beat(make_push(32'd1, rand_tags()));
        send_beat(make_push(-32'd1, rand_tags()));
        send_beat(make_push(AMP_MOST_NEG + 1, rand_tags()));
        send_beat(make_drain());
        wait_idle();
        send_beat(make_drain());

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin
                    margin_word = '1;
                    thresh_word = '0;
                end
                1: begin
                    margin_word = '0;
                    thresh_word = '1;
                end
                2: begin
                    margin_word = DW'($urandom_range(0, 2**20 - 1));
                    thresh_word = DW'($urandom_range(0, 2**22));
                end
                3: begin
                    margin_word = DW'(20'hF_FFFF);
                    thresh_word = DW'(tkms_pkg::THRESH_RESET);
                end
                default: begin
                    margin_word = DW'($urandom_range(0, 4095));
                    thresh_word = DW'($urandom());
                end
            endcase
            write_reg(tkms_pkg::REG_INSERT_MARGIN, margin_word);
            write_reg(tkms_pkg::REG_REPORT_THRESHOLD, thresh_word);
            write_reg(REG_UNMAPPED, DW'($urandom()));

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                send_burst = ($urandom_range(0, 3) == 0);
                round = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24)
                                                    : $urandom_range(1, 10);
                repeat (round) begin
                    send_beat(make_push(pick_amplitude(thresh_word), rand_tags()));
                    sent++;
                end
                send_beat(make_drain());
                sent++;
                if ($urandom_range(0, 5) == 0) begin
                    send_beat(make_drain());
                    sent++;
                end
                if ($urandom_range(0, 7) == 0) begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("top_k_magnitude_select verification clean");
        end else begin
            $display("top_k_magnitude_select verification failed");
        end
        $finish;
    end

endmodule
